/* rtl/assert_macros.svh */
// Assertion macros for the RTL of the client table.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, off during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/mctl_pkg.sv */
// Package for the client table: field widths, codes and transaction structs.
// Used by mac_client_table_lru_evict and its testbench; depends on nothing.
`default_nettype none

package mctl_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int MAC_W             = 48;
    localparam int WORD_W            = 32;
    localparam int READ_INDEX_W      = 6;
    localparam int ENTRY_INDEX_W     = 6;
    localparam int ENTRIES_USED_W    = 7;

    typedef enum logic
    {
        CMD_OBSERVE = 1'b0,
        CMD_READ    = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        KIND_ARP   = 2'd0,
        KIND_DHCP  = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_OTHER = 2'd3
    } kind_t;

    typedef struct packed
    {
        cmd_t                    command;
        logic [MAC_W-1:0]        mac_addr;
        logic [WORD_W-1:0]       ip_addr;
        kind_t                   sighting_kind;
        logic [WORD_W-1:0]       now_seconds;
        logic [READ_INDEX_W-1:0] read_index;
    } in_t;

    typedef struct packed
    {
        logic [ENTRY_INDEX_W-1:0]  entry_index;
        logic                      was_new;
        logic                      was_evicted;
        logic                      entry_valid;
        logic [MAC_W-1:0]          mac_out;
        logic [WORD_W-1:0]         ip_out;
        logic [WORD_W-1:0]         first_seen_out;
        logic [WORD_W-1:0]         last_seen_out;
        logic [WORD_W-1:0]         arp_hits;
        logic [WORD_W-1:0]         dhcp_hits;
        logic [WORD_W-1:0]         query_hits;
        logic [ENTRIES_USED_W-1:0] entries_used;
    } out_t;

    typedef struct packed
    {
        logic [MAC_W-1:0]  mac;
        logic [WORD_W-1:0] ip;
        logic [WORD_W-1:0] first_seen;
        logic [WORD_W-1:0] last_seen;
        logic [WORD_W-1:0] arp_tally;
        logic [WORD_W-1:0] dhcp_tally;
        logic [WORD_W-1:0] query_tally;
    } entry_t;

endpackage

`default_nettype wire

/* rtl/mctl_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module mctl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/mac_client_table_lru_evict.sv */
// Client table keyed by MAC address with least-recently-seen eviction.
// Depends on mctl_pkg, mctl_ram and assert_macros.svh.
//
//   channel  | signals                      | direction | payload
//   in       | in_valid, in_stall, in_data  | into      | mctl_pkg::in_t
//   out      | out_valid, out_stall, out_data | out of  | mctl_pkg::out_t
//
// Observe: the table RAM is scanned one entry a cycle, matching the MAC and
// tracking the oldest last-seen time in the same pass; an empty table skips
// the scan. A read of an index beyond the entry count skips the RAM read.
// One transaction is in work at a time; in_stall is high while it runs.
// Reset clears the entry count and the other registers; the RAM holds no reset value.
// A stalled result holds in the output register while the next transaction
// is accepted.
`default_nettype none

module mac_client_table_lru_evict #(
    parameter int TABLE_ENTRIES = mctl_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire mctl_pkg::in_t   in_data,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output mctl_pkg::out_t       out_data
);

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > mctl_pkg::READ_INDEX_W) ? CNT_W
                                                             : mctl_pkg::READ_INDEX_W;
    localparam int ENT_W  = $bits(mctl_pkg::entry_t);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_RDWAIT,
        ST_WRITE,
        ST_FINISH
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    mctl_pkg::out_t     out_data_reg, out_data_next;
    mctl_pkg::in_t      item_reg, item_next;
    mctl_pkg::entry_t   entry_reg, entry_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [mctl_pkg::WORD_W-1:0] best_reg, best_next;
    logic               fresh_reg, fresh_next;
    logic               evict_reg, evict_next;
    logic               valid_reg, valid_next;

    logic               ram_wr_en;
    logic               ram_rd_en;
    logic [IDX_W-1:0]   ram_rd_addr;
    logic [ENT_W-1:0]   ram_rd_data;
    mctl_pkg::entry_t   rd_entry;
    mctl_pkg::entry_t   upd_entry;
    logic               hit;
    logic               older;
    logic               scan_last;
    logic               table_full;
    logic               read_ok;

    function automatic mctl_pkg::entry_t blank_entry(
        input logic [mctl_pkg::MAC_W-1:0]  mac,
        input logic [mctl_pkg::WORD_W-1:0] now
    );
        mctl_pkg::entry_t e;
        e            = '0;
        e.mac        = mac;
        e.first_seen = now;
        return e;
    endfunction

    mctl_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (idx_reg),
        .wr_data (upd_entry),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rd_entry   = mctl_pkg::entry_t'(ram_rd_data);
    assign hit        = (rd_entry.mac == item_reg.mac_addr);
    assign older      = (cmp_idx_reg == '0) || (rd_entry.last_seen < best_reg);
    assign scan_last  = ((CNT_W'(cmp_idx_reg) + CNT_W'(1)) == count_reg);
    assign table_full = (count_reg == CNT_W'(TABLE_ENTRIES));
    assign read_ok    = (CMP_W'(in_data.read_index) < CMP_W'(count_reg));

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        upd_entry           = entry_reg;
        upd_entry.last_seen = item_reg.now_seconds;
        if (item_reg.ip_addr != '0)
        begin
            upd_entry.ip = item_reg.ip_addr;
        end
        unique case (item_reg.sighting_kind)
            mctl_pkg::KIND_ARP:   upd_entry.arp_tally   = entry_reg.arp_tally + 1'b1;
            mctl_pkg::KIND_DHCP:  upd_entry.dhcp_tally  = entry_reg.dhcp_tally + 1'b1;
            mctl_pkg::KIND_QUERY: upd_entry.query_tally = entry_reg.query_tally + 1'b1;
            mctl_pkg::KIND_OTHER: upd_entry             = upd_entry;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        item_next      = item_reg;
        entry_next     = entry_reg;
        idx_next       = idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        best_idx_next  = best_idx_reg;
        best_next      = best_reg;
        fresh_next     = fresh_reg;
        evict_next     = evict_reg;
        valid_next     = valid_reg;
        ram_wr_en      = 1'b0;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    fresh_next = 1'b0;
                    evict_next = 1'b0;
                    valid_next = 1'b1;
                    if (in_data.command == mctl_pkg::CMD_READ)
                    begin
                        if (read_ok)
                        begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = IDX_W'(in_data.read_index);
                            state_next  = ST_RDWAIT;
                        end
                        else
                        begin
                            entry_next = '0;
                            valid_next = 1'b0;
                            state_next = ST_FINISH;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        entry_next = blank_entry(in_data.mac_addr, in_data.now_seconds);
                        idx_next   = '0;
                        fresh_next = 1'b1;
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        ram_rd_en    = 1'b1;
                        ram_rd_addr  = '0;
                        cmp_idx_next = '0;
                        state_next   = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    entry_next = rd_entry;
                    idx_next   = cmp_idx_reg;
                    state_next = ST_WRITE;
                end
                else
                begin
                    if (older)
                    begin
                        best_next     = rd_entry.last_seen;
                        best_idx_next = cmp_idx_reg;
                    end
                    if (scan_last)
                    begin
                        fresh_next = 1'b1;
                        entry_next = blank_entry(item_reg.mac_addr, item_reg.now_seconds);
                        if (table_full)
                        begin
                            evict_next = 1'b1;
                            idx_next   = older ? cmp_idx_reg : best_idx_reg;
                        end
                        else
                        begin
                            idx_next = IDX_W'(count_reg);
                        end
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        ram_rd_en    = 1'b1;
                        ram_rd_addr  = cmp_idx_reg + 1'b1;
                        cmp_idx_next = cmp_idx_reg + 1'b1;
                    end
                end
            end
            ST_RDWAIT:
            begin
                entry_next = rd_entry;
                state_next = ST_FINISH;
            end
            ST_WRITE:
            begin
                ram_wr_en  = 1'b1;
                entry_next = upd_entry;
                if (fresh_reg && !evict_reg)
                begin
                    count_next = count_reg + 1'b1;
                end
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next.entry_index =
                        (item_reg.command == mctl_pkg::CMD_READ)
                        ? item_reg.read_index
                        : mctl_pkg::ENTRY_INDEX_W'(idx_reg);
                    out_data_next.was_new        = fresh_reg;
                    out_data_next.was_evicted    = evict_reg;
                    out_data_next.entry_valid    = valid_reg;
                    out_data_next.mac_out        = entry_reg.mac;
                    out_data_next.ip_out         = entry_reg.ip;
                    out_data_next.first_seen_out = entry_reg.first_seen;
                    out_data_next.last_seen_out  = entry_reg.last_seen;
                    out_data_next.arp_hits       = entry_reg.arp_tally;
                    out_data_next.dhcp_hits      = entry_reg.dhcp_tally;
                    out_data_next.query_hits     = entry_reg.query_tally;
                    out_data_next.entries_used   =
                        mctl_pkg::ENTRIES_USED_W'(count_reg);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            item_reg      <= '0;
            entry_reg     <= '0;
            idx_reg       <= '0;
            cmp_idx_reg   <= '0;
            best_idx_reg  <= '0;
            best_reg      <= '0;
            fresh_reg     <= 1'b0;
            evict_reg     <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            item_reg      <= item_next;
            entry_reg     <= entry_next;
            idx_reg       <= idx_next;
            cmp_idx_reg   <= cmp_idx_next;
            best_idx_reg  <= best_idx_next;
            best_reg      <= best_next;
            fresh_reg     <= fresh_next;
            evict_reg     <= evict_next;
            valid_reg     <= valid_next;
        end
    end

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(TABLE_ENTRIES), "entry count overflow")
    `ASSERT_IMPLIES(a_count_step, !$stable(count_reg),
        $past(state_reg == ST_WRITE) && (count_reg == $past(count_reg) + 1),
        "entry count changed outside a table write")
    `ASSERT_IMPLIES(a_write_addr, ram_wr_en,
        (CNT_W'(idx_reg) <= count_reg) && (CNT_W'(idx_reg) < CNT_W'(TABLE_ENTRIES)),
        "table write beyond occupied entries")
    `ASSERT_IMPLIES(a_result_src, $rose(out_valid_reg), $past(state_reg == ST_FINISH),
        "result raised outside finish")

endmodule

`default_nettype wire

/* tb/mac_client_table_lru_evict_tb.sv */
// Testbench for mac_client_table_lru_evict: a directed table, then random sightings and reads.
// Each result is checked against a table model kept here or a fixed expected result; it needs mctl_pkg and the RTL.
// Sender and receiver idle at random in several phases, with one long receiver hold-off.
`default_nettype none

module mac_client_table_lru_evict_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS         = mctl_pkg::TABLE_ENTRIES_DEF;
    localparam int POOL_SIZE    = 80;
    localparam int PHASE_ITEMS  = 190;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 100;
    localparam logic [47:0] MAC_ONES  = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] WORD_ONES = 32'hFFFF_FFFF;

    typedef struct {
        mctl_pkg::in_t  item;
        bit             fixed;
        mctl_pkg::out_t result;
    } step_row_t;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    logic           in_stall;
    mctl_pkg::in_t  in_data   = '0;
    logic           out_valid;
    logic           out_stall = 1'b0;
    mctl_pkg::out_t out_data;

    mctl_pkg::entry_t client_rows [ROWS];
    logic [6:0]       rows_used;
    mctl_pkg::out_t   pending_results [$];
    step_row_t        directed_rows [$];
    logic [47:0]      mac_pool [POOL_SIZE];
    logic [31:0]      clock_now;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    bit pressure_req   = 1'b0;
    bit hold_recv      = 1'b0;
    bit in_fire        = 1'b0;
    bit out_fire       = 1'b0;

    mac_client_table_lru_evict dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= hold_recv || ($urandom_range(0, 99) < recv_stall_pct);
    end

    function automatic logic [47:0] random_mac();
        logic [63:0] wide;
        wide = {$urandom(), $urandom()};
        return wide[47:0];
    endfunction

    function automatic mctl_pkg::out_t predict_client(mctl_pkg::in_t item);
        mctl_pkg::out_t r;
        int             i;
        int             slot;
        bit             hit;
        logic [31:0]    oldest;
        r = '0;
        r.entry_index = item.read_index;
        if (item.command == mctl_pkg::CMD_READ)
        begin
            if (item.read_index < rows_used)
            begin
                r.entry_valid    = 1'b1;
                r.mac_out        = client_rows[item.read_index].mac;
                r.ip_out         = client_rows[item.read_index].ip;
                r.first_seen_out = client_rows[item.read_index].first_seen;
                r.last_seen_out  = client_rows[item.read_index].last_seen;
                r.arp_hits       = client_rows[item.read_index].arp_tally;
                r.dhcp_hits      = client_rows[item.read_index].dhcp_tally;
                r.query_hits     = client_rows[item.read_index].query_tally;
            end
            r.entries_used = rows_used;
            return r;
        end
        hit  = 1'b0;
        slot = 0;
        for (i = 0; i < rows_used; i++)
        begin
            if (!hit && client_rows[i].mac == item.mac_addr)
            begin
                hit  = 1'b1;
                slot = i;
            end
        end
        if (!hit)
        begin
            r.was_new = 1'b1;
            if (rows_used < ROWS)
            begin
                slot      = rows_used;
                rows_used = rows_used + 7'd1;
            end
            else
            begin
                oldest = client_rows[0].last_seen;
                for (i = 1; i < ROWS; i++)
                begin
                    if (client_rows[i].last_seen < oldest)
                    begin
                        oldest = client_rows[i].last_seen;
                        slot   = i;
                    end
                end
                r.was_evicted = 1'b1;
            end
            client_rows[slot]            = '0;
            client_rows[slot].mac        = item.mac_addr;
            client_rows[slot].first_seen = item.now_seconds;
        end
        client_rows[slot].last_seen = item.now_seconds;
        if (item.ip_addr != '0)
            client_rows[slot].ip = item.ip_addr;
        case (item.sighting_kind)
            mctl_pkg::KIND_ARP:
                client_rows[slot].arp_tally = client_rows[slot].arp_tally + 32'd1;
            mctl_pkg::KIND_DHCP:
                client_rows[slot].dhcp_tally = client_rows[slot].dhcp_tally + 32'd1;
            mctl_pkg::KIND_QUERY:
                client_rows[slot].query_tally = client_rows[slot].query_tally + 32'd1;
            default: ;
        endcase
        r.entry_index    = slot[5:0];
        r.entry_valid    = 1'b1;
        r.mac_out        = client_rows[slot].mac;
        r.ip_out         = client_rows[slot].ip;
        r.first_seen_out = client_rows[slot].first_seen;
        r.last_seen_out  = client_rows[slot].last_seen;
        r.arp_hits       = client_rows[slot].arp_tally;
        r.dhcp_hits      = client_rows[slot].dhcp_tally;
        r.query_hits     = client_rows[slot].query_tally;
        r.entries_used   = rows_used;
        return r;
    endfunction

    function automatic mctl_pkg::in_t observe(logic [47:0] mac, logic [31:0] ip,
                                              mctl_pkg::kind_t kind, logic [31:0] now);
        mctl_pkg::in_t item;
        item               = '0;
        item.command       = mctl_pkg::CMD_OBSERVE;
        item.mac_addr      = mac;
        item.ip_addr       = ip;
        item.sighting_kind = kind;
        item.now_seconds   = now;
        return item;
    endfunction

    function automatic mctl_pkg::in_t read_at(logic [5:0] idx);
        mctl_pkg::in_t item;
        item            = '0;
        item.command    = mctl_pkg::CMD_READ;
        item.read_index = idx;
        return item;
    endfunction

    function automatic mctl_pkg::out_t empty_read(logic [5:0] idx, logic [6:0] used);
        mctl_pkg::out_t r;
        r              = '0;
        r.entry_index  = idx;
        r.entries_used = used;
        return r;
    endfunction

    function automatic mctl_pkg::out_t first_result(logic [5:0] idx, logic [47:0] mac,
                                                    logic [31:0] ip, logic [31:0] now,
                                                    bit arp, logic [6:0] used);
        mctl_pkg::out_t r;
        r                = '0;
        r.entry_index    = idx;
        r.was_new        = 1'b1;
        r.entry_valid    = 1'b1;
        r.mac_out        = mac;
        r.ip_out         = ip;
        r.first_seen_out = now;
        r.last_seen_out  = now;
        r.arp_hits       = arp ? 32'd1 : 32'd0;
        r.dhcp_hits      = arp ? 32'd0 : 32'd1;
        r.entries_used   = used;
        return r;
    endfunction

    function automatic void add_row(mctl_pkg::in_t item, bit fixed, mctl_pkg::out_t result);
        step_row_t row;
        row.item   = item;
        row.fixed  = fixed;
        row.result = result;
        directed_rows.push_back(row);
    endfunction

    function automatic mctl_pkg::in_t random_client_item();
        mctl_pkg::in_t item;
        int            pick;
        item               = '0;
        item.mac_addr      = random_mac();
        item.ip_addr       = $urandom();
        item.sighting_kind = mctl_pkg::kind_t'($urandom_range(0, 3));
        item.read_index    = 6'($urandom_range(0, 63));
        pick = $urandom_range(0, 99);
        if (pick < 5)
            clock_now = $urandom();
        else if (pick < 7)
            clock_now = ($urandom_range(0, 1) == 0) ? 32'd0 : WORD_ONES;
        else
            clock_now = clock_now + 32'($urandom_range(0, 2));
        item.now_seconds = ($urandom_range(0, 99) < 3) ? $urandom() : clock_now;
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            item.command = mctl_pkg::CMD_READ;
        end
        else
        begin
            item.command = mctl_pkg::CMD_OBSERVE;
            if (pick >= 30)
                item.mac_addr = mac_pool[$urandom_range(0, POOL_SIZE - 1)];
            if ($urandom_range(0, 99) < 30)
                item.ip_addr = '0;
        end
        return item;
    endfunction

    task automatic offer_item(input mctl_pkg::in_t item, input bit fixed,
                              input mctl_pkg::out_t typed);
        mctl_pkg::out_t predicted;
        bit             stalled;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        stalled = 1'b1;
        while (stalled)
        begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end
        predicted = predict_client(item);
        pending_results.push_back(fixed ? typed : predicted);
    endtask

    initial
    begin : result_monitor
        mctl_pkg::out_t seen;
        mctl_pkg::out_t wanted;
        bit             take;
        forever
        begin
            @(negedge clk);
            take     = rst_n && out_valid && !out_stall;
            seen     = out_data;
            in_fire  = rst_n && in_valid && !in_stall;
            out_fire = take;
            @(posedge clk);
            if (take)
            begin
                if (pending_results.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result: %p", seen);
                    mismatches++;
                end
                else
                begin
                    wanted = pending_results.pop_front();
                    if (seen !== wanted)
                    begin
                        if (mismatches < 10)
                            $display("result mismatch\n  expected %p\n  actual   %p",
                                     wanted, seen);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (in_fire || out_fire)
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : receiver_hold
        wait (pressure_req);
        @(negedge clk);
        hold_recv = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_recv = 1'b0;
    end

    initial
    begin : stimulus
        int             phase;
        int             i;
        int             mode;
        mctl_pkg::out_t none;
        none      = '0;
        rows_used = '0;
        clock_now = 32'd100;
        for (i = 0; i < ROWS; i++)
            client_rows[i] = '0;
        for (i = 0; i < POOL_SIZE; i++)
            mac_pool[i] = random_mac();

        add_row(read_at(6'd0), 1'b1, empty_read(6'd0, 7'd0));
        add_row(read_at(6'd63), 1'b1, empty_read(6'd63, 7'd0));
        add_row(observe('0, '0, mctl_pkg::KIND_ARP, '0), 1'b1,
                first_result(6'd0, '0, '0, '0, 1'b1, 7'd1));
        add_row(observe(MAC_ONES, WORD_ONES, mctl_pkg::KIND_DHCP, WORD_ONES), 1'b1,
                first_result(6'd1, MAC_ONES, WORD_ONES, WORD_ONES, 1'b0, 7'd2));
        add_row(read_at(6'd0), 1'b0, none);
        add_row(read_at(6'd1), 1'b0, none);
        add_row(read_at(6'd2), 1'b1, empty_read(6'd2, 7'd2));
        add_row(observe('0, 32'h0A00_0001, mctl_pkg::KIND_QUERY, 32'd5), 1'b0, none);
        add_row(observe('0, '0, mctl_pkg::KIND_OTHER, 32'd6), 1'b0, none);
        add_row(observe(MAC_ONES, '0, mctl_pkg::KIND_ARP, '0), 1'b0, none);
        add_row(observe(48'h0000_0000_0001, 32'd1, mctl_pkg::KIND_DHCP, 32'd7), 1'b0, none);
        add_row(observe(48'h8000_0000_0000, 32'h8000_0000, mctl_pkg::KIND_QUERY,
                        32'h8000_0000), 1'b0, none);
        add_row(observe(48'h5555_5555_5555, 32'hAAAA_AAAA, mctl_pkg::KIND_OTHER,
                        32'h5555_5555), 1'b0, none);
        add_row(observe(48'hAAAA_AAAA_AAAA, 32'h5555_5555, mctl_pkg::KIND_ARP,
                        32'hAAAA_AAAA), 1'b0, none);
        add_row(observe(48'h0000_0000_0001, '0, mctl_pkg::KIND_QUERY, 32'd8), 1'b0, none);
        add_row(read_at(6'd0), 1'b0, none);
        add_row(read_at(6'd1), 1'b0, none);
        add_row(read_at(6'd2), 1'b0, none);
        add_row(read_at(6'd3), 1'b0, none);
        add_row(read_at(6'd4), 1'b0, none);
        add_row(read_at(6'd5), 1'b0, none);
        add_row(read_at(6'd6), 1'b1, empty_read(6'd6, 7'd6));
        add_row(read_at(6'd63), 1'b1, empty_read(6'd63, 7'd6));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            offer_item(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].result);

        for (phase = 0; phase < 8; phase++)
        begin
            mode = phase % 4;
            send_idle_pct  = (mode == 1) ? 70 : (mode == 3) ? 9 : 0;
            recv_stall_pct = (mode == 2) ? 70 : (mode == 3) ? 9 : 0;
            if (phase == 4)
                pressure_req = 1'b1;
            for (i = 0; i < 20; i++)
                mac_pool[$urandom_range(0, POOL_SIZE - 1)] = random_mac();
            repeat (PHASE_ITEMS) offer_item(random_client_item(), 1'b0, none);
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
